// ===== hdl/token_coherence_root_directory_macros.svh =====
// token_coherence_root_directory_macros.svh
// assertion macros used by tcrd_checker.sv; no dependencies
`ifndef TOKEN_COHERENCE_ROOT_DIRECTORY_MACROS_SVH
`define TOKEN_COHERENCE_ROOT_DIRECTORY_MACROS_SVH

// implication checked on every clock edge outside reset
`define TCRD_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define TCRD_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

// ===== hdl/tcrd_pkg.sv =====
// tcrd_pkg.sv
// types, codes and default sizes for the token coherence root directory
// no dependencies
package tcrd_pkg;

   localparam int unsigned SetsDefault = 64;
   localparam int unsigned WaysDefault = 8;

   localparam logic [2:0] CMD_RD_REQ    = 3'd0;
   localparam logic [2:0] CMD_RD_DATA   = 3'd1;
   localparam logic [2:0] CMD_EVICT     = 3'd2;
   localparam logic [2:0] CMD_UPDATE    = 3'd3;
   localparam logic [2:0] CMD_DATA_TOK  = 3'd4;
   localparam logic [2:0] CMD_MEM_DONE  = 3'd5;
   localparam logic [2:0] CMD_RSVD6     = 3'd6;
   localparam logic [2:0] CMD_RSVD7     = 3'd7;

   localparam logic [2:0] ACT_FORWARD   = 3'd0;
   localparam logic [2:0] ACT_DATA_TOK  = 3'd1;
   localparam logic [2:0] ACT_MEM_READ  = 3'd2;
   localparam logic [2:0] ACT_WRITEBACK = 3'd3;
   localparam logic [2:0] ACT_ABSORB    = 3'd4;
   localparam logic [2:0] ACT_READ_RSP  = 3'd5;

   localparam logic [1:0] REG_OFFSET = 2'd0;
   localparam logic [1:0] REG_ROOTS  = 2'd1;
   localparam logic [1:0] REG_ROOTNO = 2'd2;
   localparam logic [1:0] REG_TOKENS = 2'd3;

   typedef enum logic [1:0] {
      LINE_VACANT   = 2'd0,
      LINE_FETCHING = 2'd1,
      LINE_VALID    = 2'd2,
      LINE_UNUSED   = 2'd3
   } line_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_READ,
      ST_DECIDE,
      ST_OUTPUT
   } ctrl_state_type;

   // divider handshake
   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== hdl/tcrd_divider.sv =====
// tcrd_divider.sv
// radix-2 restoring divider of a 48-bit line number by a 7-bit root count
// depends on tcrd_pkg
module tcrd_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  tcrd_pkg::div_ctrl_type    ctrl,
   input  logic [47:0]               dividend,
   input  logic [6:0]                divisor,
   output tcrd_pkg::div_stat_type    stat,
   output logic [47:0]               quotient,
   output logic [6:0]                remainder
);

   logic [47:0] quot_ff, quot_in;
   logic [6:0]  rem_ff, rem_in;
   logic [6:0]  div_ff, div_in;
   logic [5:0]  count_ff, count_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [7:0]  trial;

   always_comb begin
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      trial    = {rem_ff, quot_ff[47]};
      if (ctrl.start) begin
         quot_in  = dividend;
         rem_in   = 7'd0;
         div_in   = (divisor == 7'd0) ? 7'd1 : divisor;
         count_in = 6'd0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // one quotient bit per cycle
         if (trial >= {1'b0, div_ff}) begin
            rem_in = 7'(trial - {1'b0, div_ff});
            quot_in = {quot_ff[46:0], 1'b1};
         end else begin
            rem_in = trial[6:0];
            quot_in = {quot_ff[46:0], 1'b0};
         end
         count_in = count_ff + 6'd1;
         if (count_ff == 6'd47) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      count_ff <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

// ===== hdl/token_coherence_root_directory.sv =====
// Token coherence root directory.
// Requests enter on req_ (tvalid/tready/tdata); one response leaves on rsp_
// for every request. The user must write the registers through
// csr_we/csr_index/csr_data only while the block is idle; the block
// itself does not enforce this. A request goes from acceptance to
// rsp_tvalid through these steps: the divider is started, the line number
// is divided bit-serially by the root count, the divider is seen done, the
// set is read, the decide step writes back, and the output register is
// loaded. It is ready again only then, and takes no new request while
// one is in work. After reset the block runs a clearing pass over the
// state memory, one set a cycle, and accepts no request until it ends.
// A stalled rsp_tready holds the response in the output register; the next
// request may be worked on meanwhile and waits for the register before
// leaving.
// rsp fault marks a protocol violation seen in the request stream.
module token_coherence_root_directory #(
   parameter int unsigned SETS = tcrd_pkg::SetsDefault,
   parameter int unsigned WAYS = tcrd_pkg::WaysDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // cmd[2:0], byte_address[50:3], carried_tokens[58:51], is_dirty[59],
   // requester[67:60], zero fill to 72
   input  logic [71:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // action[2:0], out_tokens[10:3], out_requester[18:11],
   // memory_address[66:19], fault[67], zero fill to 72
   output logic [71:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [7:0]   csr_data
);

   localparam int unsigned SetBits = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int unsigned WayBits = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int unsigned ShBits  = $clog2(SETS);
   localparam int unsigned TagWidth = 48;
   localparam int unsigned RowWidth = WAYS * (2 + TagWidth + 8 + 8);

   typedef struct packed {
      logic [1:0]          st;
      logic [TagWidth-1:0] tag;
      logic [7:0]          tok;
      logic [7:0]          req;
   } way_type;

   // configuration
   logic [3:0] offs_ff;
   logic [6:0] roots_ff;
   logic [5:0] rootno_ff;
   logic [7:0] total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offs_ff   <= 4'd6;
         roots_ff  <= 7'd1;
         rootno_ff <= 6'd0;
         total_ff  <= 8'd16;
      end else if (csr_we) begin
         case (csr_index)
            tcrd_pkg::REG_OFFSET: offs_ff   <= csr_data[3:0];
            tcrd_pkg::REG_ROOTS:  roots_ff  <= csr_data[6:0];
            tcrd_pkg::REG_ROOTNO: rootno_ff <= csr_data[5:0];
            tcrd_pkg::REG_TOKENS: total_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // request fields
   logic [2:0]  cmd_ff;
   logic [47:0] line_ff;
   logic [7:0]  tok_ff;
   logic        dirty_ff;
   logic [7:0]  reqr_ff;

   tcrd_pkg::ctrl_state_type state_ff, state_in;
   logic [SetBits:0] clr_ff;
   logic             clearing;
   assign clearing = (clr_ff != (SetBits+1)'(SETS));

   // divider
   tcrd_pkg::div_ctrl_type dctl;
   tcrd_pkg::div_stat_type dstat;
   logic [47:0] quot;
   logic [6:0]  rem;

   tcrd_divider u_div (
      .clock(clock), .reset(reset), .ctrl(dctl),
      .dividend(line_ff), .divisor(roots_ff),
      .stat(dstat), .quotient(quot), .remainder(rem)
   );

   // memory
   logic [RowWidth-1:0] mem [SETS];
   logic [RowWidth-1:0] rd_ff;
   logic [RowWidth-1:0] wr_row;
   logic                wr_en;
   logic [SetBits-1:0]  set_idx;
   logic [SetBits-1:0]  wr_idx;

   assign set_idx = (SETS > 1) ? SetBits'(line_ff) : '0;
   assign wr_idx  = clearing ? clr_ff[SetBits-1:0] : set_idx;

   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_idx] <= wr_row;
      rd_ff <= mem[set_idx];
   end

   always_ff @(posedge clock) begin
      if (reset)
         clr_ff <= '0;
      else if (clearing)
         clr_ff <= clr_ff + 1'b1;
   end

   // output register
   logic        ovalid_ff;
   logic [71:0] odata_ff;
   logic [71:0] result_ff, result_in;

   // decide logic
   way_type ways [WAYS];
   way_type nways [WAYS];
   logic [TagWidth-1:0] tag;
   logic        hit;
   logic [WayBits-1:0] hit_w;
   logic        freev;
   logic [WayBits-1:0] free_w;
   logic        ours;
   logic [2:0]  act;
   logic [7:0]  otok, oreq;
   logic [47:0] oaddr;
   logic        fault;
   logic [8:0]  sum;
   logic [47:0] memaddr;

   assign tag = TagWidth'(line_ff >> ShBits);
   assign memaddr = quot << offs_ff;

   always_comb begin
      for (int i = 0; i < WAYS; i++)
         ways[i] = rd_ff[i*$bits(way_type) +: $bits(way_type)];
      hit = 1'b0; hit_w = '0; freev = 1'b0; free_w = '0;
      for (int i = 0; i < WAYS; i++) begin
         if (ways[i].st == tcrd_pkg::LINE_VACANT) begin
            freev = 1'b1; free_w = WayBits'(i);
         end else if (!hit && ways[i].tag == tag) begin
            hit = 1'b1; hit_w = WayBits'(i);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < WAYS; i++) nways[i] = ways[i];
      ours  = ({1'b0, rem} == {2'b0, rootno_ff});
      act   = tcrd_pkg::ACT_FORWARD;
      otok  = tok_ff; oreq = 8'd0; oaddr = 48'd0; fault = 1'b0;
      sum   = {1'b0, tok_ff} + {1'b0, ways[hit_w].tok};
      if (cmd_ff == tcrd_pkg::CMD_MEM_DONE) begin
         act = tcrd_pkg::ACT_READ_RSP;
         otok = total_ff;
         if (!hit) begin
            fault = 1'b1; oreq = reqr_ff;
         end else begin
            if (ways[hit_w].st != tcrd_pkg::LINE_FETCHING) fault = 1'b1;
            oreq = ways[hit_w].req;
            nways[hit_w].st = tcrd_pkg::LINE_VALID;
         end
      end else if (ours) begin
         case (cmd_ff)
            tcrd_pkg::CMD_RD_REQ: begin
               if (!hit && freev) begin
                  nways[free_w].tag = tag;
                  nways[free_w].tok = 8'd0;
                  nways[free_w].st  = tcrd_pkg::LINE_FETCHING;
                  nways[free_w].req = reqr_ff;
                  act = tcrd_pkg::ACT_MEM_READ;
                  oaddr = memaddr;
               end
            end
            tcrd_pkg::CMD_RD_DATA: begin
               if (!hit && !freev) begin
                  fault = 1'b1;
               end else if (!hit) begin
                  nways[free_w].tag = tag;
                  nways[free_w].tok = 8'd0;
                  nways[free_w].st  = tcrd_pkg::LINE_VALID;
                  act = tcrd_pkg::ACT_DATA_TOK;
                  otok = total_ff;
               end else if (ways[hit_w].tok != 8'd0) begin
                  act = tcrd_pkg::ACT_DATA_TOK;
                  otok = ways[hit_w].tok;
                  nways[hit_w].tok = 8'd0;
               end
            end
            tcrd_pkg::CMD_EVICT: begin
               if (!hit) begin
                  fault = 1'b1; act = tcrd_pkg::ACT_ABSORB; otok = 8'd0;
               end else begin
                  if (ways[hit_w].st != tcrd_pkg::LINE_VALID) fault = 1'b1;
                  if (sum > {1'b0, total_ff}) fault = 1'b1;
                  if (sum < {1'b0, total_ff}) begin
                     nways[hit_w].tok = sum[7:0];
                     act = tcrd_pkg::ACT_ABSORB; otok = 8'd0;
                  end else begin
                     nways[hit_w].st = tcrd_pkg::LINE_VACANT;
                     if (dirty_ff) begin
                        act = tcrd_pkg::ACT_WRITEBACK; oaddr = memaddr;
                     end else begin
                        act = tcrd_pkg::ACT_ABSORB; otok = 8'd0;
                     end
                  end
               end
            end
            tcrd_pkg::CMD_RSVD6, tcrd_pkg::CMD_RSVD7: fault = 1'b1;
            default: ;
         endcase
      end
   end

   // control
   always_comb begin
      state_in  = state_ff;
      dctl.start = 1'b0;
      wr_en     = clearing;
      wr_row    = '0;
      result_in = result_ff;
      req_tready = (state_ff == tcrd_pkg::ST_IDLE) && !clearing;
      case (state_ff)
         tcrd_pkg::ST_IDLE: begin
            if (req_tvalid && !clearing) begin
               state_in = tcrd_pkg::ST_DIVIDE;
            end
         end
         tcrd_pkg::ST_DIVIDE: begin
            if (!dstat.busy && !dstat.done) dctl.start = 1'b1;
            if (dstat.done) state_in = tcrd_pkg::ST_READ;
         end
         tcrd_pkg::ST_READ: state_in = tcrd_pkg::ST_DECIDE;
         tcrd_pkg::ST_DECIDE: begin
            wr_en = 1'b1;
            for (int i = 0; i < WAYS; i++)
               wr_row[i*$bits(way_type) +: $bits(way_type)] = nways[i];
            result_in = {4'd0, fault, oaddr, oreq, otok, act};
            state_in = tcrd_pkg::ST_OUTPUT;
         end
         tcrd_pkg::ST_OUTPUT: begin
            if (!ovalid_ff || rsp_tready) state_in = tcrd_pkg::ST_IDLE;
         end
         default: state_in = tcrd_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= tcrd_pkg::ST_IDLE;
      else       state_ff <= state_in;
      result_ff <= result_in;
      if (req_tvalid && req_tready) begin
         cmd_ff   <= req_tdata[2:0];
         line_ff  <= req_tdata[50:3] >> offs_ff;
         tok_ff   <= req_tdata[58:51];
         dirty_ff <= req_tdata[59];
         reqr_ff  <= req_tdata[67:60];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else if (state_ff == tcrd_pkg::ST_OUTPUT && (!ovalid_ff || rsp_tready)) begin
         ovalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         ovalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == tcrd_pkg::ST_OUTPUT && (!ovalid_ff || rsp_tready))
         odata_ff <= result_ff;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;

endmodule

// ===== hdl/tcrd_checker.sv =====
// tcrd_checker.sv
// port-level assertions for the root directory, bound to the top level
// depends on token_coherence_root_directory_macros.svh and tcrd_pkg
`include "token_coherence_root_directory_macros.svh"

module tcrd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [71:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata
);

   // a stalled response holds
   `TCRD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // one request in flight: no new request right after accepting one
   `TCRD_ASSERT_NEXT(a_one_inflight, clock, reset, req_tvalid && req_tready, !req_tready)
   // action code is never beyond read response
   `TCRD_ASSERT_IMP(a_action_range, clock, reset, rsp_tvalid, rsp_tdata[2:0] <= tcrd_pkg::ACT_READ_RSP)
   // fill bits stay zero
   `TCRD_ASSERT_IMP(a_fill_zero, clock, reset, rsp_tvalid, rsp_tdata[71:68] == 4'd0)

endmodule

bind token_coherence_root_directory tcrd_checker u_tcrd_checker (
   .clock(clock), .reset(reset),
   .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
